// File: hdl/simcc_keypoint_decoder_macros.svh
// ----------------------------------------------------------------------------
// simcc keypoint decoder assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef SIMCC_KEYPOINT_DECODER_MACROS_SVH
`define SIMCC_KEYPOINT_DECODER_MACROS_SVH

// same-cycle implication
`define SKD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SKD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/skd_pkg.sv
// ----------------------------------------------------------------------------
// skd_pkg
// types and constants of the simcc keypoint decoder
// ----------------------------------------------------------------------------
package skd_pkg;

  // size defaults
  localparam int DEF_MAX_BINS   = 1024;
  localparam int DEF_MAX_POINTS = 32;

  // field widths
  localparam int SCORE_W     = 16;
  localparam int BIN_CFG_W   = 11;
  localparam int PTS_CFG_W   = 6;
  localparam int COORD_CFG_W = 16;
  localparam int INDEX_W     = 5;
  localparam int POS_W       = 20;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 64;

  // saturation limit of a position
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_X_BIN_COUNT = 3'd0,
    REG_Y_BIN_COUNT = 3'd1,
    REG_POINT_COUNT = 3'd2,
    REG_X_ORIGIN    = 3'd3,
    REG_Y_ORIGIN    = 3'd4,
    REG_X_STEP      = 3'd5,
    REG_Y_STEP      = 3'd6
  } cfg_reg_t;

  // register reset values
  localparam logic [BIN_CFG_W-1:0]   RST_X_BIN_COUNT = 11'd384;
  localparam logic [BIN_CFG_W-1:0]   RST_Y_BIN_COUNT = 11'd512;
  localparam logic [PTS_CFG_W-1:0]   RST_POINT_COUNT = 6'd17;
  localparam logic [COORD_CFG_W-1:0] RST_ORIGIN      = 16'd0;
  localparam logic [COORD_CFG_W-1:0] RST_STEP        = 16'd256;

endpackage

// File: hdl/simcc_keypoint_decoder.sv
// ----------------------------------------------------------------------------
// simcc_keypoint_decoder
// per-keypoint argmax over an x row and a y row of scores, mapped to
// picture positions in 1/16 pixel with saturation
// ----------------------------------------------------------------------------
// throughput: one score item per cycle, set by the compare and counter update
//   of the running maximum; s_tready drops at a y row end while capture is held
// result path: the final score of a y row is captured, then its bins are
//   multiplied by the step, then rounded and origin added into the result register
// reset: synchronous rst restores register defaults, clears counters, best
//   values and all stage valid flags; x row comes first after reset
module simcc_keypoint_decoder
  import skd_pkg::*;
#(
  parameter int MAX_BINS   = DEF_MAX_BINS,
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic                  clk,
  input  logic                  rst,
  // score stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] bin_score
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [4:0] point_index, [24:5] x_position,
                                           // [44:25] y_position, [60:45] point_score,
                                           // [63:61] zero
  output logic                  m_tlast,   // last_point
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int BW     = $clog2(MAX_BINS);
  localparam int CNT_W  = (BW + 1 > BIN_CFG_W) ? BW + 1 : BIN_CFG_W;
  localparam int PW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PC_W   = (PW + 1 > PTS_CFG_W) ? PW + 1 : PTS_CFG_W;
  localparam int PRODW  = BW + COORD_CFG_W;

  // configuration registers
  logic [BIN_CFG_W-1:0]   x_bin_count;
  logic [BIN_CFG_W-1:0]   y_bin_count;
  logic [PTS_CFG_W-1:0]   point_count;
  logic [COORD_CFG_W-1:0] x_origin;
  logic [COORD_CFG_W-1:0] y_origin;
  logic [COORD_CFG_W-1:0] x_step;
  logic [COORD_CFG_W-1:0] y_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_bin_count <= RST_X_BIN_COUNT;
      y_bin_count <= RST_Y_BIN_COUNT;
      point_count <= RST_POINT_COUNT;
      x_origin    <= RST_ORIGIN;
      y_origin    <= RST_ORIGIN;
      x_step      <= RST_STEP;
      y_step      <= RST_STEP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_X_BIN_COUNT: x_bin_count <= cfg_data[BIN_CFG_W-1:0];
        REG_Y_BIN_COUNT: y_bin_count <= cfg_data[BIN_CFG_W-1:0];
        REG_POINT_COUNT: point_count <= cfg_data[PTS_CFG_W-1:0];
        REG_X_ORIGIN:    x_origin    <= cfg_data;
        REG_Y_ORIGIN:    y_origin    <= cfg_data;
        REG_X_STEP:      x_step      <= cfg_data;
        REG_Y_STEP:      y_step      <= cfg_data;
        default: ;
      endcase
    end
  end

  // running state
  logic                      in_y_row;
  logic [BW-1:0]             bin_counter;
  logic signed [SCORE_W-1:0] best_x_score;
  logic [BW-1:0]             best_x_bin;
  logic signed [SCORE_W-1:0] best_y_score;
  logic [BW-1:0]             best_y_bin;
  logic [PW-1:0]             point_counter;

  // pipeline stage flags
  logic ev_valid;
  logic mul_valid;
  logic out_ok;
  logic mul_ok;
  logic ev_ok;

  // row and frame end decode
  logic [CNT_W-1:0]          row_cnt_raw;
  logic [CNT_W-1:0]          row_cnt;
  logic                      row_end;
  logic [PC_W-1:0]           pts_raw;
  logic [PC_W-1:0]           pts;
  logic                      frame_end;
  logic signed [SCORE_W-1:0] score_in;
  logic                      take_new;
  logic                      emit;
  logic                      accept;
  logic                      ev_load;

  assign score_in = $signed(s_tdata[SCORE_W-1:0]);

  always_comb begin
    row_cnt_raw = in_y_row ? CNT_W'(y_bin_count) : CNT_W'(x_bin_count);
    if (row_cnt_raw == '0) begin
      row_cnt = CNT_W'(1);
    end else if (row_cnt_raw > CNT_W'(MAX_BINS)) begin
      row_cnt = CNT_W'(MAX_BINS);
    end else begin
      row_cnt = row_cnt_raw;
    end
    row_end = (CNT_W'(bin_counter) + CNT_W'(1)) >= row_cnt;

    pts_raw = PC_W'(point_count);
    if (pts_raw == '0) begin
      pts = PC_W'(1);
    end else if (pts_raw > PC_W'(MAX_POINTS)) begin
      pts = PC_W'(MAX_POINTS);
    end else begin
      pts = pts_raw;
    end
    frame_end = (PC_W'(point_counter) + PC_W'(1)) >= pts;

    take_new = (bin_counter == '0) ||
               (score_in > (in_y_row ? best_y_score : best_x_score));
  end

  // stage handshakes, a stage loads when empty or when it drains
  assign out_ok   = !m_tvalid || m_tready;
  assign mul_ok   = !mul_valid || out_ok;
  assign ev_ok    = !ev_valid || mul_ok;
  assign emit     = in_y_row && row_end;
  assign s_tready = !emit || ev_ok;
  assign accept   = s_tvalid && s_tready;
  assign ev_load  = accept && emit;

  // running maximum and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      in_y_row      <= 1'b0;
      bin_counter   <= '0;
      best_x_score  <= '0;
      best_x_bin    <= '0;
      best_y_score  <= '0;
      best_y_bin    <= '0;
      point_counter <= '0;
    end else if (accept) begin
      if (!in_y_row) begin
        if (take_new) begin
          best_x_score <= score_in;
          best_x_bin   <= bin_counter;
        end
      end else begin
        if (take_new) begin
          best_y_score <= score_in;
          best_y_bin   <= bin_counter;
        end
      end
      if (row_end) begin
        bin_counter <= '0;
        in_y_row    <= !in_y_row;
      end else begin
        bin_counter <= bin_counter + BW'(1);
      end
      if (emit) begin
        point_counter <= frame_end ? '0 : point_counter + PW'(1);
      end
    end
  end

  // capture stage: peak bins and scores of the finished keypoint
  logic [BW-1:0]             ev_x_bin;
  logic [BW-1:0]             ev_y_bin;
  logic signed [SCORE_W-1:0] ev_x_score;
  logic signed [SCORE_W-1:0] ev_y_score;
  logic [INDEX_W-1:0]        ev_index;
  logic                      ev_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (ev_ok) begin
      ev_valid <= ev_load;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_ok && ev_load) begin
      ev_x_bin   <= best_x_bin;
      ev_y_bin   <= take_new ? bin_counter : best_y_bin;
      ev_x_score <= best_x_score;
      ev_y_score <= take_new ? score_in : best_y_score;
      ev_index   <= INDEX_W'(PC_W'(point_counter));
      ev_last    <= frame_end;
    end
  end

  // multiply stage: bin times step, and the smaller peak score
  logic [PRODW-1:0]          mul_x_prod;
  logic [PRODW-1:0]          mul_y_prod;
  logic signed [SCORE_W-1:0] mul_score;
  logic [INDEX_W-1:0]        mul_index;
  logic                      mul_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (mul_ok) begin
      mul_valid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ok && ev_valid) begin
      mul_x_prod <= PRODW'(ev_x_bin) * PRODW'(x_step);
      mul_y_prod <= PRODW'(ev_y_bin) * PRODW'(y_step);
      mul_score  <= (ev_x_score < ev_y_score) ? ev_x_score : ev_y_score;
      mul_index  <= ev_index;
      mul_last   <= ev_last;
    end
  end

  // round to 1/16 pixel, add origin, saturate
  logic [PRODW:0]   x_rnd;
  logic [PRODW:0]   y_rnd;
  logic [PRODW:0]   x_sum;
  logic [PRODW:0]   y_sum;
  logic [POS_W-1:0] x_pos_next;
  logic [POS_W-1:0] y_pos_next;

  always_comb begin
    x_rnd      = {1'b0, mul_x_prod} + (PRODW + 1)'(8);
    y_rnd      = {1'b0, mul_y_prod} + (PRODW + 1)'(8);
    x_sum      = (PRODW + 1)'(x_origin) + (x_rnd >> 4);
    y_sum      = (PRODW + 1)'(y_origin) + (y_rnd >> 4);
    x_pos_next = (x_sum > (PRODW + 1)'(POS_MAX)) ? POS_MAX : x_sum[POS_W-1:0];
    y_pos_next = (y_sum > (PRODW + 1)'(POS_MAX)) ? POS_MAX : y_sum[POS_W-1:0];
  end

  // result register
  logic [INDEX_W-1:0]        out_index;
  logic [POS_W-1:0]          out_x_pos;
  logic [POS_W-1:0]          out_y_pos;
  logic signed [SCORE_W-1:0] out_score;
  logic                      out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ok) begin
      m_tvalid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ok && mul_valid) begin
      out_index <= mul_index;
      out_x_pos <= x_pos_next;
      out_y_pos <= y_pos_next;
      out_score <= mul_score;
      out_last  <= mul_last;
    end
  end

  assign m_tdata = {3'b000, out_score, out_y_pos, out_x_pos, out_index};
  assign m_tlast = out_last;

  // checks
`include "simcc_keypoint_decoder_macros.svh"

  `SKD_ASSERT_NEXT(a_row_wrap, ev_load, !in_y_row && bin_counter == '0, "x row not restarted")
  `SKD_ASSERT_IMPL(a_stall_cause, !s_tready, emit && ev_valid, "stall without full capture")
  `SKD_ASSERT_NEXT(a_frame_wrap, ev_load && frame_end, point_counter == '0, "no point wrap")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// simcc keypoint decoder testbench
// streams score rows into the decoder, predicts every keypoint result
// (argmax bins, rounded and saturated positions, min peak score, frame end)
// and compares each result item against the oldest prediction; both
// streams stall at random and config is rewritten between phases
// ----------------------------------------------------------------------------
module tb_top;
  import skd_pkg::*;

  localparam int MAX_BINS     = DEF_MAX_BINS;
  localparam int MAX_POINTS   = DEF_MAX_POINTS;
  localparam int RANDOM_ITEMS = 100;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 500000;

  // one decoded keypoint
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [POS_W-1:0]   x_pos;
    logic [POS_W-1:0]   y_pos;
    logic [SCORE_W-1:0] score;
    logic               last;
  } keypoint_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // predictor copy of the registers
  logic [BIN_CFG_W-1:0]   x_bins_reg = RST_X_BIN_COUNT;
  logic [BIN_CFG_W-1:0]   y_bins_reg = RST_Y_BIN_COUNT;
  logic [PTS_CFG_W-1:0]   points_reg = RST_POINT_COUNT;
  logic [COORD_CFG_W-1:0] x_org      = RST_ORIGIN;
  logic [COORD_CFG_W-1:0] y_org      = RST_ORIGIN;
  logic [COORD_CFG_W-1:0] x_step_reg = RST_STEP;
  logic [COORD_CFG_W-1:0] y_step_reg = RST_STEP;

  // predictor copy of the decode state
  int unsigned        row_pos    = 0;
  logic               on_y_row   = 1'b0;
  logic signed [15:0] peak_x     = '0;
  logic signed [15:0] peak_y     = '0;
  logic [9:0]         peak_x_bin = '0;
  logic [9:0]         peak_y_bin = '0;
  int unsigned        point_num  = 0;

  keypoint_t pending_points[$];

  int src_idle_pct  = 30;
  int sink_idle_pct = 30;
  int items_sent    = 0;
  int points_made   = 0;
  int results_seen  = 0;
  int reg_writes    = 0;
  int error_count   = 0;
  int cycle_count   = 0;

  simcc_keypoint_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),     // [15:0] bin_score
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),     // [4:0] point_index, [24:5] x_position,
                              // [44:25] y_position, [60:45] point_score
    .m_tlast   (m_tlast),     // last_point
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic int unsigned clamp_len(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // origin + round(bin * step / 16), saturated to the position width
  function automatic logic [POS_W-1:0] to_position(input logic [15:0] origin,
                                                   input logic [9:0] bin,
                                                   input logic [15:0] step);
    longint unsigned p;
    p = longint'(origin) + ((longint'(bin) * longint'(step) + 8) >> 4);
    return (p > longint'(POS_MAX)) ? POS_MAX : POS_W'(p);
  endfunction

  task automatic track_score(input logic signed [15:0] sc);
    int unsigned row_len;
    int unsigned frame_len;
    logic        row_done;
    keypoint_t   kp;
    row_len  = clamp_len(on_y_row ? int'(y_bins_reg) : int'(x_bins_reg), MAX_BINS);
    row_done = (row_pos + 1 >= row_len);
    if (!on_y_row) begin
      // first maximum of the x row wins ties
      if (row_pos == 0 || sc > peak_x) begin
        peak_x     = sc;
        peak_x_bin = 10'(row_pos);
      end
      if (row_done) begin
        row_pos  = 0;
        on_y_row = 1'b1;
      end else begin
        row_pos++;
      end
    end else begin
      if (row_pos == 0 || sc > peak_y) begin
        peak_y     = sc;
        peak_y_bin = 10'(row_pos);
      end
      if (!row_done) begin
        row_pos++;
      end else begin
        // end of y row: one keypoint result
        frame_len = clamp_len(int'(points_reg), MAX_POINTS);
        kp.last   = (point_num + 1 >= frame_len);
        kp.index  = INDEX_W'(point_num);
        kp.x_pos  = to_position(x_org, peak_x_bin, x_step_reg);
        kp.y_pos  = to_position(y_org, peak_y_bin, y_step_reg);
        kp.score  = (peak_x < peak_y) ? peak_x : peak_y;
        pending_points.push_back(kp);
        points_made++;
        row_pos   = 0;
        on_y_row  = 1'b0;
        point_num = kp.last ? 0 : point_num + 1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int draw_wait(input int pct);
    if ($urandom_range(99) < pct) return $urandom_range(15);
    return 0;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 30;
      default: return 100;
    endcase
  endfunction

  // score mix: extremes, near-zero values that tie often, full range
  function automatic logic [15:0] pick_score();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom_range(4)) - 16'd2;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_bins();
    case ($urandom_range(9))
      0:       return 16'd0;
      1, 2:    return 16'($urandom_range(40, 9));
      default: return 16'($urandom_range(8, 1));
    endcase
  endfunction

  function automatic logic [15:0] rand_points();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'($urandom_range(63, 33));
      default: return 16'($urandom_range(6, 1));
    endcase
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // valid stays high after an item unless a gap follows
  task automatic send_score(input logic [15:0] sc);
    int gap;
    gap = draw_wait(src_idle_pct);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sc;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    track_score(sc);
    items_sent++;
  endtask

  // scores until the predictor sees one more keypoint
  task automatic send_keypoint();
    int target;
    target = points_made + 1;
    while (points_made < target) send_score(pick_score());
  endtask

  // drop valid, drain all results, then cover the pipeline latency
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_X_BIN_COUNT: x_bins_reg = val[BIN_CFG_W-1:0];
      REG_Y_BIN_COUNT: y_bins_reg = val[BIN_CFG_W-1:0];
      REG_POINT_COUNT: points_reg = val[PTS_CFG_W-1:0];
      REG_X_ORIGIN:    x_org      = val;
      REG_Y_ORIGIN:    y_org      = val;
      REG_X_STEP:      x_step_reg = val;
      REG_Y_STEP:      y_step_reg = val;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [15:0] xb, input logic [15:0] yb,
                           input logic [15:0] pts, input logic [15:0] xo,
                           input logic [15:0] yo, input logic [15:0] xs,
                           input logic [15:0] ys);
    write_reg(REG_X_BIN_COUNT, xb);
    write_reg(REG_Y_BIN_COUNT, yb);
    write_reg(REG_POINT_COUNT, pts);
    write_reg(REG_X_ORIGIN, xo);
    write_reg(REG_Y_ORIGIN, yo);
    write_reg(REG_X_STEP, xs);
    write_reg(REG_Y_STEP, ys);
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic check_result();
    keypoint_t got;
    keypoint_t want;
    got.index = m_tdata[4:0];
    got.x_pos = m_tdata[24:5];
    got.y_pos = m_tdata[44:25];
    got.score = m_tdata[60:45];
    got.last  = m_tlast;
    results_seen++;
    if (pending_points.size() == 0) begin
      error_count++;
      $error("keypoint item with none expected: point_index %0d", got.index);
      return;
    end
    want = pending_points.pop_front();
    if (got.index !== want.index) begin
      error_count++;
      $error("point_index: expected %0d, got %0d", want.index, got.index);
    end
    if (got.x_pos !== want.x_pos) begin
      error_count++;
      $error("x_position: expected %0d, got %0d", want.x_pos, got.x_pos);
    end
    if (got.y_pos !== want.y_pos) begin
      error_count++;
      $error("y_position: expected %0d, got %0d", want.y_pos, got.y_pos);
    end
    if (got.score !== want.score) begin
      error_count++;
      $error("point_score: expected %0d, got %0d", $signed(want.score), $signed(got.score));
    end
    if (got.last !== want.last) begin
      error_count++;
      $error("last_point: expected %0d, got %0d", want.last, got.last);
    end
  endtask

  // result sink with random stalls
  initial begin : result_sink
    int stall;
    forever begin
      stall = draw_wait(sink_idle_pct);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (rst || !m_tvalid) @(posedge clk);
      check_result();
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // x row begun at the reset length, then a short keypoint with origin,
  // step and point count as left by reset
  task automatic test_reset_values();
    src_idle_pct  = 0;
    sink_idle_pct = 50;
    repeat (3) send_score(pick_score());
    settle();
    write_reg(REG_X_BIN_COUNT, 16'd4);
    write_reg(REG_Y_BIN_COUNT, 16'd2);
    send_keypoint();
    settle();
  endtask

  // single-score rows with extreme scores, min of the two peaks
  task automatic test_score_extremes();
    src_idle_pct  = 30;
    sink_idle_pct = 30;
    write_all(16'd1, 16'd1, 16'd2, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
    send_score(16'h7FFF);
    send_score(16'h7FFF);
    send_score(16'h8000);
    send_score(16'h7FFF);
    send_score(16'h0000);
    send_score(16'hFFFF);
    send_score(16'h0001);
    send_score(16'h0000);
    settle();
  endtask

  // equal maxima keep the first bin; half-unit rounding goes up
  task automatic test_first_peak_wins();
    write_all(16'd4, 16'd3, 16'd1, 16'd100, 16'd200, 16'd24, 16'd8);
    send_score(16'd5);
    send_score(16'd9);
    send_score(16'd9);
    send_score(16'd2);
    repeat (3) send_score(-16'sd3);
    repeat (4) send_score(16'h8000);
    send_score(-16'sd7);
    send_score(16'd4);
    send_score(16'd4);
    settle();
  endtask

  // zero counts act as one, oversized counts clamp, index wraps after 31
  task automatic test_count_clamps();
    write_all(16'd0, 16'd0, 16'd0, 16'd16, 16'd32, 16'd256, 16'd256);
    repeat (3) send_keypoint();
    settle();
    write_reg(REG_POINT_COUNT, 16'd63);
    repeat (MAX_POINTS + 1) send_keypoint();
    settle();
  endtask

  // counts lowered while a row or a frame is under way
  task automatic test_shrink_mid_stream();
    write_all(16'd8, 16'd8, 16'd1, 16'd0, 16'd0, 16'd4096, 16'd1000);
    send_keypoint();
    settle();
    // x row cut short after five scores
    repeat (5) send_score(pick_score());
    settle();
    write_reg(REG_X_BIN_COUNT, 16'd2);
    send_score(pick_score());
    // y row cut short after three scores
    repeat (3) send_score(pick_score());
    settle();
    write_reg(REG_Y_BIN_COUNT, 16'd1);
    send_score(pick_score());
    settle();
    // frame cut short after three keypoints
    write_reg(REG_X_BIN_COUNT, 16'd1);
    write_reg(REG_POINT_COUNT, 16'd5);
    repeat (3) send_keypoint();
    settle();
    write_reg(REG_POINT_COUNT, 16'd2);
    repeat (2) send_keypoint();
    settle();
  endtask

  // oversized x row clamped to full length, peak at the final bin,
  // saturated positions
  task automatic test_long_rows();
    src_idle_pct  = 10;
    sink_idle_pct = 30;
    write_all(16'h07FF, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (MAX_BINS - 1) send_score(16'($urandom_range(100)) - 16'd50);
    send_score(16'h7FFF);
    send_score(pick_score());
    settle();
    write_all(16'd0, 16'd5, 16'd1, 16'd0, 16'h8000, 16'd0, 16'hFFFF);
    send_keypoint();
    settle();
  endtask

  // random configs, whole keypoints, now and then a partial row
  task automatic test_random_frames();
    int start;
    int npts;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      settle();
      src_idle_pct  = pick_pct();
      sink_idle_pct = pick_pct();
      write_all(rand_bins(), rand_bins(), rand_points(), rand_coord(),
                rand_coord(), rand_coord(), rand_coord());
      npts = $urandom_range(12, 1);
      repeat (npts) send_keypoint();
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(10, 1)) send_score(pick_score());
      end
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_score_extremes();
    test_first_peak_wins();
    test_count_clamps();
    test_shrink_mid_stream();
    test_long_rows();
    test_random_frames();
    settle();
    $display("summary: %0d score items, %0d keypoint items checked, %0d register writes",
             items_sent, results_seen, reg_writes);
    $display("summary: reset values, ties, clamped counts, mid-row and mid-frame shrink, saturation");
    if (error_count == 0 && pending_points.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/skd_pkg.sv
hdl/simcc_keypoint_decoder.sv
tb/tb_top.sv
